/* rtl/core/date_record_insertion_sorter_assert.svh */
// Assertion macros for the date record sorter.
// Each use expands to one labeled concurrent assertion on clk, held off during reset.
`ifndef DATE_RECORD_INSERTION_SORTER_ASSERT_SVH
`define DATE_RECORD_INSERTION_SORTER_ASSERT_SVH

// Same-cycle implication.
`define DRS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/drs_pkg.sv */
`default_nettype none
package drs_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int TAG_W   = 16;
  localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;

  typedef struct packed {
    logic [YEAR_W-1:0]  rec_year;
    logic [MONTH_W-1:0] rec_month;
    logic [DAY_W-1:0]   rec_day;
    logic [TAG_W-1:0]   record_tag;
    logic               final_record;
  } in_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    logic [TAG_W-1:0]   out_tag;
    logic               out_last;
    logic               overflowed;
  } out_t;

  // One stored record.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [TAG_W-1:0]   tag;
  } rec_t;

  // What a cell loads at the next edge.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD_NEW,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctrl_t;

  function automatic logic [KEY_W-1:0] rec_key(input rec_t r);
    rec_key = {r.year, r.month, r.day};
  endfunction

endpackage
`default_nettype wire

/* rtl/core/drs_cell.sv */
`default_nettype none
module drs_cell (
  input  wire               clk,
  input  drs_pkg::cell_ctrl_t ctrl,
  input  drs_pkg::rec_t     new_rec,
  input  drs_pkg::rec_t     prev_rec,
  input  drs_pkg::rec_t     next_rec,
  output drs_pkg::rec_t     rec_r,
  output logic              later
);

  drs_pkg::rec_t rec_nxt;

  // Stored date strictly after the incoming one: incoming goes in front of it.
  assign later = drs_pkg::rec_key(rec_r) > drs_pkg::rec_key(new_rec);

  always_comb begin
    case (ctrl.op)
      drs_pkg::CELL_HOLD:       rec_nxt = rec_r;
      drs_pkg::CELL_LOAD_NEW:   rec_nxt = new_rec;
      drs_pkg::CELL_SHIFT_UP:   rec_nxt = prev_rec;
      drs_pkg::CELL_SHIFT_DOWN: rec_nxt = next_rec;
      default:                  rec_nxt = rec_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule
`default_nettype wire

/* rtl/core/date_record_insertion_sorter.sv */
`default_nettype none
// Channel  | Ports                     | Transfer
// ---------+---------------------------+-----------------------------------------
// input    | start, busy, in_data      | rising edge with start high, busy low
// result   | out_strobe, out_data      | every cycle out_strobe is high
//
// A non-final record is taken every cycle while busy is low: the new record
// is broadcast to the row of cells, each compares it with its own entry, and
// the row shifts up and drops it into place at the edge that takes it. A final
// record holds busy high while the row shifts down one cell a cycle toward
// cell 0, which drives the result, until every stored record is out. Reset
// clears the count, overflow flag and state; the cells keep no valid bits,
// occupancy comes from the count. There is no backpressure on results.
module date_record_insertion_sorter #(
  parameter int CAPACITY = drs_pkg::CAPACITY_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          start,
  output logic         busy,
  input  drs_pkg::in_t in_data,
  output logic         out_strobe,
  output drs_pkg::out_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t         state_r;
  state_t         state_nxt;
  logic [CW-1:0]  count_r;
  logic [CW-1:0]  count_nxt;
  logic           ovf_r;
  logic           ovf_nxt;

  logic           accept;
  logic           full;
  logic           insert_en;

  drs_pkg::rec_t      new_rec;
  drs_pkg::rec_t      cell_rec [CAPACITY];
  drs_pkg::cell_ctrl_t cell_ctrl [CAPACITY];
  logic [CAPACITY-1:0] later;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] later_occ;
  logic [CAPACITY-1:0] open_slot;

  assign busy       = (state_r == ST_EMIT);
  assign out_strobe = (state_r == ST_EMIT);
  assign accept     = start & ~busy;
  assign full       = (count_r == CW'(CAPACITY));
  assign insert_en  = accept & ~full;

  assign new_rec.year  = in_data.rec_year;
  assign new_rec.month = in_data.rec_month;
  assign new_rec.day   = in_data.rec_day;
  assign new_rec.tag   = in_data.record_tag;

  // Row of cells. Cell i inserts the new record when it is the first slot that
  // is empty or holds a later date; every later occupied cell passes its entry
  // up by one. Equal dates stay in front, which keeps the order stable.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i]       = count_r > CW'(i);
    assign later_occ[i] = occ[i] & later[i];
    assign open_slot[i] = later_occ[i] | ~occ[i];

    logic ins_here;
    logic shift_in;
    if (i == 0) begin : g_first
      assign ins_here = open_slot[i];
      assign shift_in = 1'b0;
    end else begin : g_rest
      assign ins_here = open_slot[i] & ~open_slot[i-1];
      assign shift_in = later_occ[i-1];
    end

    always_comb begin
      if (state_r == ST_EMIT) begin
        cell_ctrl[i].op = drs_pkg::CELL_SHIFT_DOWN;
      end else if (insert_en && shift_in) begin
        cell_ctrl[i].op = drs_pkg::CELL_SHIFT_UP;
      end else if (insert_en && ins_here) begin
        cell_ctrl[i].op = drs_pkg::CELL_LOAD_NEW;
      end else begin
        cell_ctrl[i].op = drs_pkg::CELL_HOLD;
      end
    end

    drs_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl[i]),
      .new_rec  (new_rec),
      .prev_rec ((i == 0) ? new_rec : cell_rec[(i == 0) ? 0 : i-1]),
      .next_rec ((i == CAPACITY-1) ? cell_rec[i] : cell_rec[(i == CAPACITY-1) ? i : i+1]),
      .rec_r    (cell_rec[i]),
      .later    (later[i])
    );
  end

  // Result comes straight off cell 0; the count doubles as the remaining count.
  assign out_data.out_year   = cell_rec[0].year;
  assign out_data.out_month  = cell_rec[0].month;
  assign out_data.out_day    = cell_rec[0].day;
  assign out_data.out_tag    = cell_rec[0].tag;
  assign out_data.out_last   = (count_r == CW'(1));
  assign out_data.overflowed = ovf_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          // Drop the record when full and remember it for the whole set.
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CW'(1);
          end
          if (in_data.final_record) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (count_r == CW'(1)) begin
          state_nxt = ST_IDLE;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

`include "date_record_insertion_sorter_assert.svh"

  `DRS_ASSERT_SAME(a_emit_nonempty, out_strobe, count_r != '0, "emit with empty store")
  `DRS_ASSERT_NEXT(a_final_emits, accept && in_data.final_record, out_strobe, "final not emitted")
  `DRS_ASSERT_NEXT(a_last_ends, out_strobe && out_data.out_last, !busy && count_r == '0, "run did not end")
  `DRS_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(CAPACITY), "count beyond capacity")

endmodule
`default_nettype wire
